// ----- sv/spq_pkg.sv -----
// Shared types and codes for the stable priority queue.
package spq_pkg;

  localparam int VAL_W = 32;
  localparam int PRI_W = 8;

  localparam logic [1:0] CMD_ENQUEUE = 2'd0;
  localparam logic [1:0] CMD_DEQUEUE = 2'd1;
  localparam logic [1:0] CMD_PEEK    = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [PRI_W-1:0]        pri;
    logic signed [VAL_W-1:0] value;
  } entry_t;

endpackage

// ----- sv/spq_slot_ram.sv -----
// Slot memory: one write port, one read port with registered read data.
module spq_slot_ram import spq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  entry_t                   wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output entry_t                   rd_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/stable_priority_queue.sv -----
// Stable priority queue top level: sequencer, ring pointers and slot memory.
//
// Bounded priority queue of CAPACITY entries held in a ring in priority order;
// entries of equal priority leave in arrival order. One command is taken at a
// time and in_ready stays low until its result has been transferred. A refused
// enqueue, an enqueue into an empty queue, an empty queue report or an unused
// command code goes straight to the result state; dequeue or peek of a stored
// entry first reads the head slot; an enqueue into a non-empty queue moves each
// stored entry of lower priority back one slot and then places the new entry.
// The enqueue walk runs from the tail toward the head through the single read
// port of the slot memory and one priority comparator, one entry per cycle.
// After the result transfer the block is ready again in the next cycle.
module stable_priority_queue import spq_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              command,
  input  logic signed [VAL_W-1:0] item_value,
  input  logic [PRI_W-1:0]        item_priority,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VAL_W-1:0] head_value,
  output logic [1:0]              status
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_HEAD  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_PLACE = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t                  state, state_next;
  logic [CW-1:0]           fill_count, fill_count_next;
  logic [AW-1:0]           base, base_next;
  logic [AW-1:0]           idx, idx_next;
  logic [1:0]              op_cmd;
  logic signed [VAL_W-1:0] op_value;
  logic [PRI_W-1:0]        op_pri;
  logic signed [VAL_W-1:0] res_value, res_value_next;
  logic [1:0]              res_status, res_status_next;
  logic                    res_load;

  logic                    rd_en, wr_en;
  logic [AW-1:0]           rd_lidx, wr_lidx;
  entry_t                  wr_data, rd_data;

  // logical slot to ring address
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base_i,
                                         input logic [AW-1:0] lidx);
    logic [AW:0] sum;
    sum = {1'b0, base_i} + {1'b0, lidx};
    if (sum >= (AW+1)'(CAPACITY)) begin
      sum = sum - (AW+1)'(CAPACITY);
    end
    return sum[AW-1:0];
  endfunction

  spq_slot_ram #(.DEPTH(CAPACITY)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (phys(base, wr_lidx)),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (phys(base, rd_lidx)),
    .rd_data (rd_data)
  );

  assign in_ready   = (state == S_IDLE);
  assign out_valid  = (state == S_DONE);
  assign head_value = res_value;
  assign status     = res_status;

  always_comb begin
    state_next      = state;
    fill_count_next = fill_count;
    base_next       = base;
    idx_next        = idx;
    rd_en           = 1'b0;
    rd_lidx         = '0;
    wr_en           = 1'b0;
    wr_lidx         = idx;
    wr_data.value   = op_value;
    wr_data.pri     = op_pri;
    res_load        = 1'b0;
    res_value_next  = '0;
    res_status_next = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (command)
            CMD_ENQUEUE: begin
              if (fill_count == CW'(CAPACITY)) begin
                res_load        = 1'b1;
                res_status_next = ST_FULL;
                state_next      = S_DONE;
              end else if (fill_count == '0) begin
                wr_en           = 1'b1;
                wr_lidx         = '0;
                wr_data.value   = item_value;
                wr_data.pri     = item_priority;
                fill_count_next = fill_count + CW'(1);
                res_load        = 1'b1;
                state_next      = S_DONE;
              end else begin
                rd_en      = 1'b1;
                rd_lidx    = AW'(fill_count - CW'(1));
                idx_next   = fill_count[AW-1:0];
                state_next = S_SCAN;
              end
            end
            CMD_DEQUEUE, CMD_PEEK: begin
              if (fill_count == '0) begin
                res_load        = 1'b1;
                res_status_next = ST_EMPTY;
                state_next      = S_DONE;
              end else begin
                rd_en      = 1'b1;
                rd_lidx    = '0;
                state_next = S_HEAD;
              end
            end
            default: begin
              res_load   = 1'b1;
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_HEAD: begin
        res_load       = 1'b1;
        res_value_next = rd_data.value;
        if (op_cmd == CMD_DEQUEUE) begin
          base_next       = phys(base, AW'(1));
          fill_count_next = fill_count - CW'(1);
        end
        state_next = S_DONE;
      end
      S_SCAN: begin
        wr_en = 1'b1;
        if (rd_data.pri < op_pri) begin
          // lower priority entry moves back one slot
          wr_data  = rd_data;
          idx_next = idx - AW'(1);
          if (idx == AW'(1)) begin
            state_next = S_PLACE;
          end else begin
            rd_en   = 1'b1;
            rd_lidx = idx - AW'(2);
          end
        end else begin
          fill_count_next = fill_count + CW'(1);
          res_load        = 1'b1;
          state_next      = S_DONE;
        end
      end
      S_PLACE: begin
        wr_en           = 1'b1;
        fill_count_next = fill_count + CW'(1);
        res_load        = 1'b1;
        state_next      = S_DONE;
      end
      S_DONE: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= '0;
      base       <= '0;
    end else begin
      state      <= state_next;
      fill_count <= fill_count_next;
      base       <= base_next;
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (in_valid && in_ready) begin
      op_cmd   <= command;
      op_value <= item_value;
      op_pri   <= item_priority;
    end
    if (res_load) begin
      res_value  <= res_value_next;
      res_status <= res_status_next;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CW'(CAPACITY))
    else $error("fill count above capacity");

  a_base_bound: assert property (@(posedge clk) disable iff (rst)
    base < AW'(CAPACITY - 1) || base == AW'(CAPACITY - 1))
    else $error("ring base out of range");

  a_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> head_value == '0)
    else $error("nonzero value with error status");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready again right after input transfer");

  a_full_refused: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> fill_count == CW'(CAPACITY))
    else $error("full status with room left");

endmodule
